// ----- rtl/core/mtsp_pkg.sv -----
package mtsp_pkg;

    localparam int COORD_W = 32;
    localparam int MULT_W  = COORD_W + 1;
    localparam int GAIN_W  = 48;
    localparam int ORIG_W  = 48;
    localparam int DIM_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int GAIN_LO_W = 16;
    localparam int PP_LO_W = MULT_W + GAIN_LO_W + 1;
    localparam int PP_HI_W = MULT_W + GAIN_W - GAIN_LO_W;
    localparam int SUM_W   = MULT_W + GAIN_W;
    localparam int FRAC_W  = 32;
    localparam int RND_W   = SUM_W - FRAC_W;

    localparam logic [CFG_IDX_W-1:0] REG_X_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_ORIGIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 3'd5;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET   = 48'sd4294967296;
    localparam logic signed [ORIG_W-1:0] ORIGIN_RESET = 48'sd0;
    localparam logic [DIM_W-1:0]         WIDTH_RESET  = 16'd640;
    localparam logic [DIM_W-1:0]         HEIGHT_RESET = 16'd480;

    typedef struct packed {
        logic en2;
        logic en3;
    } t_pipe_ctl;

    typedef struct packed {
        logic load;
        logic last;
    } t_box_ctl;

endpackage

// ----- rtl/core/mtsp_scale.sv -----
module mtsp_scale (
    input  logic                                   i_clk,
    input  mtsp_pkg::t_pipe_ctl                    i_ctl,
    input  logic signed [mtsp_pkg::MULT_W-1:0]     i_m,
    input  logic signed [mtsp_pkg::GAIN_W-1:0]     i_gain,
    input  logic signed [mtsp_pkg::ORIG_W-1:0]     i_origin,
    output logic signed [mtsp_pkg::RND_W-1:0]      o_rounded
);

    localparam logic [mtsp_pkg::SUM_W-1:0] HALF = 81'd1 << (mtsp_pkg::FRAC_W - 1);

    logic signed [mtsp_pkg::PP_LO_W-1:0] n_pp_lo;
    logic signed [mtsp_pkg::PP_HI_W-1:0] n_pp_hi;
    logic signed [mtsp_pkg::PP_LO_W-1:0] r_pp_lo;
    logic signed [mtsp_pkg::PP_HI_W-1:0] r_pp_hi;
    logic [mtsp_pkg::SUM_W-1:0]          w_sum;
    logic signed [mtsp_pkg::RND_W-1:0]   r_rounded;

    // split gain into low 16 unsigned bits and signed high part
    assign n_pp_lo = i_m * $signed({1'b0, i_gain[mtsp_pkg::GAIN_LO_W-1:0]});
    assign n_pp_hi = i_m * $signed(i_gain[mtsp_pkg::GAIN_W-1:mtsp_pkg::GAIN_LO_W]);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_pp_lo <= n_pp_lo;
            r_pp_hi <= n_pp_hi;
        end
    end

    assign w_sum = {r_pp_hi, {mtsp_pkg::GAIN_LO_W{1'b0}}}
                 + {{(mtsp_pkg::SUM_W - mtsp_pkg::PP_LO_W){r_pp_lo[mtsp_pkg::PP_LO_W-1]}},
                    r_pp_lo}
                 + {{(mtsp_pkg::SUM_W - mtsp_pkg::ORIG_W - 16){i_origin[mtsp_pkg::ORIG_W-1]}},
                    i_origin, 16'd0}
                 + HALF;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_rounded <= $signed(w_sum[mtsp_pkg::SUM_W-1:mtsp_pkg::FRAC_W]);
        end
    end

    assign o_rounded = r_rounded;

endmodule

// ----- rtl/core/mtsp_box.sv -----
module mtsp_box (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  mtsp_pkg::t_box_ctl                     i_ctl,
    input  logic signed [mtsp_pkg::RND_W-1:0]      i_rx,
    input  logic signed [mtsp_pkg::RND_W-1:0]      i_ry,
    input  logic [mtsp_pkg::DIM_W-1:0]             i_width,
    input  logic [mtsp_pkg::DIM_W-1:0]             i_height,
    output logic signed [mtsp_pkg::COORD_W-1:0]    o_sx,
    output logic signed [mtsp_pkg::COORD_W-1:0]    o_sy,
    output logic                                   o_visible
);

    localparam int CW = mtsp_pkg::COORD_W;

    function automatic logic signed [CW-1:0] sat(input logic signed [mtsp_pkg::RND_W-1:0] v);
        logic signed [CW-1:0] res;
        if (v > $signed({{(mtsp_pkg::RND_W-CW+1){1'b0}}, {(CW-1){1'b1}}})) begin
            res = {1'b0, {(CW-1){1'b1}}};
        end else if (v < $signed({{(mtsp_pkg::RND_W-CW+1){1'b1}}, {(CW-1){1'b0}}})) begin
            res = {1'b1, {(CW-1){1'b0}}};
        end else begin
            res = v[CW-1:0];
        end
        return res;
    endfunction

    logic signed [CW-1:0] r_min_x, r_max_x, r_min_y, r_max_y;
    logic signed [CW-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic                 r_first_pending;
    logic signed [CW-1:0] w_sx, w_sy;

    assign w_sx = sat(i_rx);
    assign w_sy = sat(i_ry);

    always_comb begin
        if (r_first_pending) begin
            n_min_x = w_sx;
            n_max_x = w_sx;
            n_min_y = w_sy;
            n_max_y = w_sy;
        end else begin
            n_min_x = (w_sx < r_min_x) ? w_sx : r_min_x;
            n_max_x = (w_sx > r_max_x) ? w_sx : r_max_x;
            n_min_y = (w_sy < r_min_y) ? w_sy : r_min_y;
            n_max_y = (w_sy > r_max_y) ? w_sy : r_max_y;
        end
    end

    assign o_sx = w_sx;
    assign o_sy = w_sy;
    assign o_visible = i_ctl.last
                     && !n_max_x[CW-1]
                     && ($signed({n_min_x[CW-1], n_min_x})
                         < $signed({{(CW+1-mtsp_pkg::DIM_W){1'b0}}, i_width}))
                     && !n_max_y[CW-1]
                     && ($signed({n_min_y[CW-1], n_min_y})
                         < $signed({{(CW+1-mtsp_pkg::DIM_W){1'b0}}, i_height}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x         <= '0;
            r_max_x         <= '0;
            r_min_y         <= '0;
            r_max_y         <= '0;
            r_first_pending <= 1'b1;
        end else if (i_ctl.load) begin
            r_min_x         <= n_min_x;
            r_max_x         <= n_max_x;
            r_min_y         <= n_min_y;
            r_max_y         <= n_max_y;
            r_first_pending <= i_ctl.last;
        end
    end

endmodule

// ----- rtl/core/map_to_screen_point_transform.sv -----
// pipeline: four register stages, the result is valid once a point reaches the fourth
// throughput: one point per cycle, sustained under no output stall
// stages: input register, split gain multiply, 81-bit rounding add, saturate and box
// reset: synchronous active low; clears stage valids, restores register defaults
// and restarts the bounding box at the next point
module map_to_screen_point_transform (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [63:0]                       i_s_axis_tdata,   // map_x, map_y
    input  logic                              i_s_axis_tlast,   // last_point
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [63:0]                       o_m_axis_tdata,   // screen_x, screen_y
    output logic                              o_m_axis_tlast,   // is_last
    output logic                              o_m_axis_tuser,   // visible
    input  logic                              i_cfg_we,
    input  logic [mtsp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtsp_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int CW = mtsp_pkg::COORD_W;

    logic signed [mtsp_pkg::GAIN_W-1:0] r_x_gain, r_y_gain;
    logic signed [mtsp_pkg::ORIG_W-1:0] r_x_origin, r_y_origin;
    logic [mtsp_pkg::DIM_W-1:0]         r_width, r_height;

    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_last1, r_last2, r_last3, r_last4;
    logic signed [mtsp_pkg::MULT_W-1:0] r_mx, r_my;
    logic signed [mtsp_pkg::RND_W-1:0]  w_rx, w_ry;
    logic signed [CW-1:0]               w_sx, w_sy;
    logic                               w_visible;
    logic [63:0]                        r_out_data;
    logic                               r_out_vis;
    mtsp_pkg::t_pipe_ctl                w_pipe_ctl;
    mtsp_pkg::t_box_ctl                 w_box_ctl;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_gain   <= mtsp_pkg::GAIN_RESET;
            r_y_gain   <= mtsp_pkg::GAIN_RESET;
            r_x_origin <= mtsp_pkg::ORIGIN_RESET;
            r_y_origin <= mtsp_pkg::ORIGIN_RESET;
            r_width    <= mtsp_pkg::WIDTH_RESET;
            r_height   <= mtsp_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mtsp_pkg::REG_X_GAIN:   r_x_gain   <= $signed(i_cfg_wdata);
                mtsp_pkg::REG_Y_GAIN:   r_y_gain   <= $signed(i_cfg_wdata);
                mtsp_pkg::REG_X_ORIGIN: r_x_origin <= $signed(i_cfg_wdata);
                mtsp_pkg::REG_Y_ORIGIN: r_y_origin <= $signed(i_cfg_wdata);
                mtsp_pkg::REG_SCREEN_W: r_width    <= i_cfg_wdata[mtsp_pkg::DIM_W-1:0];
                mtsp_pkg::REG_SCREEN_H: r_height   <= i_cfg_wdata[mtsp_pkg::DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // stage enables, bubbles collapse
    assign w_en4 = !r_v4 || i_m_axis_tready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign o_s_axis_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_s_axis_tvalid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // input register, y is negated here
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_mx    <= $signed({i_s_axis_tdata[CW-1], i_s_axis_tdata[CW-1:0]});
            r_my    <= $signed(33'd0 - {i_s_axis_tdata[2*CW-1], i_s_axis_tdata[2*CW-1:CW]});
            r_last1 <= i_s_axis_tlast;
        end
        if (w_en2) r_last2 <= r_last1;
        if (w_en3) r_last3 <= r_last2;
    end

    assign w_pipe_ctl.en2 = w_en2;
    assign w_pipe_ctl.en3 = w_en3;

    mtsp_scale u_scale_x (
        .i_clk     (i_clk),
        .i_ctl     (w_pipe_ctl),
        .i_m       (r_mx),
        .i_gain    (r_x_gain),
        .i_origin  (r_x_origin),
        .o_rounded (w_rx)
    );

    mtsp_scale u_scale_y (
        .i_clk     (i_clk),
        .i_ctl     (w_pipe_ctl),
        .i_m       (r_my),
        .i_gain    (r_y_gain),
        .i_origin  (r_y_origin),
        .o_rounded (w_ry)
    );

    assign w_box_ctl.load = w_en4 && r_v3;
    assign w_box_ctl.last = r_last3;

    mtsp_box u_box (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_box_ctl),
        .i_rx      (w_rx),
        .i_ry      (w_ry),
        .i_width   (r_width),
        .i_height  (r_height),
        .o_sx      (w_sx),
        .o_sy      (w_sy),
        .o_visible (w_visible)
    );

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out_data <= {w_sy, w_sx};
            r_last4    <= r_last3;
            r_out_vis  <= w_visible;
        end
    end

    assign o_m_axis_tvalid = r_v4;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_last4;
    assign o_m_axis_tuser  = r_out_vis;

`ifndef SYNTHESIS
    a_vis_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast)
        else $error("visible on a request that is not last");

    a_full_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && r_v4 && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("request accepted into a full pipeline");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_v1 && r_v2 && r_v3 && r_v4) |-> o_s_axis_tready)
        else $error("ready low with an empty stage");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && !r_v4 |=> r_v4)
        else $error("finished request not moved to output");
`endif

endmodule
